// ===== hdl/catg_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// catg_pkg
// Shared constants and types for the caustic alpha texture generator.
// ---------------------------------------------------------------------------
package catg_pkg;

    // texture geometry: 256 x 256 texels, split into four parity banks
    localparam int TEX_DIM     = 256;
    localparam int TEX_DEPTH   = TEX_DIM * TEX_DIM;
    localparam int BANK_CNT    = 4;
    localparam int BANK_DEPTH  = TEX_DEPTH / BANK_CNT;

    // visible image
    localparam int IMAGE_WIDTH  = 128;
    localparam int IMAGE_HEIGHT = 64;

    // result queue depth (at least 3 for back-to-back pixel items)
    localparam int OUT_DEPTH_DEF = 4;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // 1.0 in 16-bit fraction units
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    // coordinate offsets for frame counter zero: (1<<16)/6, 0, 0
    localparam logic [23:0] OFS6_RST  = 24'h002AAA;
    localparam logic [23:0] OFS8_RST  = 24'h000000;
    localparam logic [23:0] OFS10_RST = 24'h000000;

    // alpha curve knees
    localparam logic [7:0] ALPHA_KNEE_HI = 8'd160;
    localparam logic [7:0] ALPHA_KNEE_LO = 8'd128;

    typedef logic [7:0] texel_t;

    // sideband travelling with a sample through the filter
    typedef struct packed {
        logic        vld;
        logic        second;
        logic [23:0] rgb;
    } catg_tag_t;

endpackage : catg_pkg
`default_nettype wire

// ===== hdl/catg_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// catg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module catg_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16384
) (
    input  wire logic                       clk,
    input  wire logic                       wen,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [DATA_W-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [DATA_W-1:0]          rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
        if (wen)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

endmodule : catg_ram
`default_nettype wire

// ===== hdl/catg_bilerp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// catg_bilerp
// Two-stage bilinear filter: horizontal blend, then vertical blend.
// ---------------------------------------------------------------------------
module catg_bilerp
    import catg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire catg_tag_t         tag_in,
    input  wire texel_t [3:0]      texel,   // p00, p10, p01, p11
    input  wire logic [15:0]       fx,
    input  wire logic [15:0]       fy,
    output catg_tag_t              tag_out,
    output texel_t                 sample
);

    catg_tag_t   h_tag_reg;
    logic [23:0] h0_reg;
    logic [23:0] h1_reg;
    logic [15:0] h_fy_reg;

    logic [16:0] gx;
    logic [24:0] h0_next;
    logic [24:0] h1_next;
    logic [16:0] gy;
    logic [40:0] v_sum;

    // horizontal: row values scaled by 65536
    always_comb
    begin
        gx      = FRAC_ONE - {1'b0, fx};
        h0_next = 25'(texel[0]) * 25'(gx) + 25'(texel[1]) * 25'(fx);
        h1_next = 25'(texel[2]) * 25'(gx) + 25'(texel[3]) * 25'(fx);
    end

    // vertical: total scaled by 2^32, truncated
    always_comb
    begin
        gy    = FRAC_ONE - {1'b0, h_fy_reg};
        v_sum = 41'(h0_reg) * 41'(gy) + 41'(h1_reg) * 41'(h_fy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_tag_reg <= '0;
            tag_out   <= '0;
        end
        else
        begin
            h_tag_reg <= tag_in;
            tag_out   <= h_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg   <= h0_next[23:0];
        h1_reg   <= h1_next[23:0];
        h_fy_reg <= fy;
        sample   <= v_sum[39:32];
    end

endmodule : catg_bilerp
`default_nettype wire

// ===== hdl/caustic_alpha_texture_generator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// caustic_alpha_texture_generator
// Holds a 256x256 grey texture and turns pixel items into ARGB words whose
// alpha comes from two averaged bilinear samples of the animated texture.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  -------------------------------
//  input     in         in_valid / in_stall    func, texel_address,
//                                              texel_value, pixel_x, pixel_y,
//                                              old_rgb
//  output    out        out_valid / out_stall  pixel_argb
//  config    in         cfg_wen                cfg_wdata (frame counter)
//
//  A load item writes one texel; a pixel item's eight texel reads go to four
//  parity banks with one read port each, four reads per cycle, so its two
//  samples are read in turn. Results pass the read stage and the filter
//  registers to the output queue. No clearing pass after reset: texels are
//  undefined until loaded. in_stall rises while a pixel reads its second
//  sample and whenever the result queue has no room reserved for another
//  pixel; out_stall only holds the queue head.
// ---------------------------------------------------------------------------
module caustic_alpha_texture_generator
    import catg_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF   // result queue depth, >= 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wen,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [15:0] texel_address,
    input  wire logic [7:0]  texel_value,
    input  wire logic [6:0]  pixel_x,
    input  wire logic [5:0]  pixel_y,
    input  wire logic [23:0] old_rgb,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      pixel_argb
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int BA_W  = $clog2(BANK_DEPTH);
    localparam logic [8:0] IMG_W9 = 9'(IMAGE_WIDTH);
    localparam logic [8:0] IMG_H9 = 9'(IMAGE_HEIGHT);

    // ---------------------------------------------------------------------
    // Frame-dependent coordinate offsets, worked out on the config write.
    // Signed division of (f << 16) truncates toward zero: divide the
    // magnitude by reciprocal multiply or shift, then restore the sign.
    // ---------------------------------------------------------------------
    logic [23:0] ofs6_reg;
    logic [23:0] ofs8_reg;
    logic [23:0] ofs10_reg;

    logic [15:0] f_next;      // frame + 1, wraps
    logic [31:0] mag0;
    logic [31:0] mag1;
    logic [63:0] prod6;
    logic [63:0] prod10;
    logic [23:0] q6;
    logic [23:0] q8;
    logic [23:0] q10;
    logic [23:0] ofs6_next;
    logic [23:0] ofs8_next;
    logic [23:0] ofs10_next;

    always_comb
    begin
        f_next = cfg_wdata + 16'd1;
        mag0   = cfg_wdata[15] ? {16'd0 - cfg_wdata, 16'h0000} : {cfg_wdata, 16'h0000};
        mag1   = f_next[15]    ? {16'd0 - f_next, 16'h0000}    : {f_next, 16'h0000};
        // x/6 = (x * 0xAAAAAAAB) >> 34, x/10 = (x * 0xCCCCCCCD) >> 35
        prod6  = {32'h0, mag1} * 64'h0000_0000_AAAA_AAAB;
        prod10 = {32'h0, mag0} * 64'h0000_0000_CCCC_CCCD;
        q6     = prod6[57:34];
        q10    = prod10[58:35];
        q8     = mag0[26:3];
        ofs6_next  = f_next[15]    ? 24'd0 - q6  : q6;
        ofs8_next  = cfg_wdata[15] ? 24'd0 - q8  : q8;
        ofs10_next = cfg_wdata[15] ? 24'd0 - q10 : q10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs6_reg  <= OFS6_RST;
            ofs8_reg  <= OFS8_RST;
            ofs10_reg <= OFS10_RST;
        end
        else if (cfg_wen)
        begin
            ofs6_reg  <= ofs6_next;
            ofs8_reg  <= ofs8_next;
            ofs10_reg <= ofs10_next;
        end
    end

    // ---------------------------------------------------------------------
    // Input acceptance and the pixel read sequence
    // ---------------------------------------------------------------------
    logic             phase_reg;      // reading the second sample of a pixel
    logic [CNT_W-1:0] resv_reg;       // pixels in flight plus queued results
    logic [CNT_W-1:0] resv_next;
    logic             in_go;
    logic             pix_go;
    logic             load_go;
    logic             in_image;
    logic             out_go;

    assign in_stall = phase_reg || (resv_reg == CNT_W'(OUT_DEPTH));
    assign in_go    = in_valid && !in_stall;
    assign in_image = ({2'b00, pixel_x} < IMG_W9) && ({3'b000, pixel_y} < IMG_H9);
    assign pix_go   = in_go && (func == FUNC_PIXEL) && in_image;
    assign load_go  = in_go && (func == FUNC_LOAD);
    assign out_go   = out_valid && !out_stall;

    always_comb
    begin
        resv_next = resv_reg;
        if (pix_go && !out_go)
        begin
            resv_next = resv_reg + CNT_W'(1);
        end
        else if (!pix_go && out_go)
        begin
            resv_next = resv_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            resv_reg  <= '0;
        end
        else
        begin
            phase_reg <= pix_go;
            resv_reg  <= resv_next;
        end
    end

    // ---------------------------------------------------------------------
    // Sample coordinates, 16.16 with only bits 23..0 significant.
    // Sample one straight from the item, sample two held for the next cycle.
    // ---------------------------------------------------------------------
    logic [23:0] tu;
    logic [6:0]  vy_neg;
    logic [23:0] u1;
    logic [23:0] v1;
    logic [23:0] u2;
    logic [23:0] v2;
    logic [23:0] u2_reg;
    logic [23:0] v2_reg;
    logic [23:0] rgb_reg;
    logic [23:0] u_rd;
    logic [23:0] v_rd;

    always_comb
    begin
        tu     = {pixel_x, 17'h0};
        vy_neg = 7'd0 - {1'b0, pixel_y};          // (256 - y) mod 128
        u1     = tu - ofs6_reg;
        v1     = {vy_neg, 17'h0} + ofs8_reg;
        u2     = tu + ofs10_reg;
        v2     = {1'b0, pixel_y, 17'h0};
        u_rd   = phase_reg ? u2_reg : u1;
        v_rd   = phase_reg ? v2_reg : v1;
    end

    always_ff @(posedge clk)
    begin
        if (pix_go)
        begin
            u2_reg  <= u2;
            v2_reg  <= v2;
            rgb_reg <= old_rgb;
        end
    end

    // ---------------------------------------------------------------------
    // Texture banks: bank index = {row parity, column parity}, so the four
    // neighbours of one sample always fall in four different banks.
    // ---------------------------------------------------------------------
    function automatic logic [BA_W-1:0] bank_addr(input logic [7:0] x0,
                                                  input logic [7:0] y0,
                                                  input logic [1:0] bank);
        logic [7:0] xs;
        logic [7:0] ys;
        xs = (x0[0] == bank[0]) ? x0 : x0 + 8'd1;
        ys = (y0[0] == bank[1]) ? y0 : y0 + 8'd1;
        return BA_W'({ys[7:1], xs[7:1]});
    endfunction

    texel_t          bank_rdata [BANK_CNT];
    logic [1:0]      wr_bank;
    logic [BA_W-1:0] wr_addr;

    assign wr_bank = {texel_address[8], texel_address[0]};
    assign wr_addr = BA_W'({texel_address[15:9], texel_address[7:1]});

    for (genvar b = 0; b < BANK_CNT; b++)
    begin : g_bank
        catg_ram #(
            .DATA_W (8),
            .DEPTH  (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .wen   (load_go && (wr_bank == 2'(b))),
            .waddr (wr_addr),
            .wdata (texel_value),
            .raddr (bank_addr(u_rd[23:16], v_rd[23:16], 2'(b))),
            .rdata (bank_rdata[b])
        );
    end

    // ---------------------------------------------------------------------
    // Read stage: sideband aligned with the registered bank data
    // ---------------------------------------------------------------------
    catg_tag_t    rd_tag_reg;
    catg_tag_t    rd_tag_next;
    logic         rd_x0p_reg;
    logic         rd_y0p_reg;
    logic [15:0]  rd_fx_reg;
    logic [15:0]  rd_fy_reg;
    texel_t [3:0] texel;

    always_comb
    begin
        rd_tag_next.vld    = pix_go || phase_reg;
        rd_tag_next.second = phase_reg;
        rd_tag_next.rgb    = phase_reg ? rgb_reg : old_rgb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
        end
        else
        begin
            rd_tag_reg <= rd_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x0p_reg <= u_rd[16];
        rd_y0p_reg <= v_rd[16];
        rd_fx_reg  <= u_rd[15:0];
        rd_fy_reg  <= v_rd[15:0];
    end

    // put bank outputs back in neighbour order
    always_comb
    begin
        texel[0] = bank_rdata[{rd_y0p_reg,  rd_x0p_reg}];
        texel[1] = bank_rdata[{rd_y0p_reg, ~rd_x0p_reg}];
        texel[2] = bank_rdata[{~rd_y0p_reg,  rd_x0p_reg}];
        texel[3] = bank_rdata[{~rd_y0p_reg, ~rd_x0p_reg}];
    end

    // ---------------------------------------------------------------------
    // Bilinear filter, shared by both samples of a pixel
    // ---------------------------------------------------------------------
    catg_tag_t bl_tag;
    texel_t    bl_sample;

    catg_bilerp u_bilerp (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (rd_tag_reg),
        .texel   (texel),
        .fx      (rd_fx_reg),
        .fy      (rd_fy_reg),
        .tag_out (bl_tag),
        .sample  (bl_sample)
    );

    // ---------------------------------------------------------------------
    // Average, alpha curve, alpha/3 and packing
    // ---------------------------------------------------------------------
    texel_t      s1_reg;
    logic [8:0]  avg_sum;
    logic [7:0]  avg;
    logic [7:0]  avg_lo;
    logic [7:0]  alpha;
    logic [15:0] third_prod;
    logic [31:0] argb;

    always_ff @(posedge clk)
    begin
        if (bl_tag.vld && !bl_tag.second)
        begin
            s1_reg <= bl_sample;
        end
    end

    always_comb
    begin
        avg_sum = {1'b0, s1_reg} + {1'b0, bl_sample};
        avg     = avg_sum[8:1];
        avg_lo  = avg - ALPHA_KNEE_LO;
        priority if (avg >= ALPHA_KNEE_HI)
        begin
            alpha = 8'd255 - {avg[6:0] - ALPHA_KNEE_HI[6:0], 1'b0};
        end
        else if (avg >= ALPHA_KNEE_LO)
        begin
            alpha = {avg_lo[5:0], 2'b00} + avg_lo;
        end
        else
        begin
            alpha = 8'd0;
        end
        // x/3 = (x * 171) >> 9, exact for 8-bit x
        third_prod = 16'(alpha) * 16'd171;
        argb       = {1'b0, third_prod[15:9], bl_tag.rgb};
    end

    // ---------------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------------
    logic [31:0]      fifo_mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fifo_cnt_reg;
    logic [CNT_W-1:0] fifo_cnt_next;
    logic             fifo_wen;

    assign fifo_wen   = bl_tag.vld && bl_tag.second;
    assign out_valid  = (fifo_cnt_reg != '0);
    assign pixel_argb = fifo_mem_reg[rd_ptr_reg];

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_wen && !out_go)
        begin
            fifo_cnt_next = fifo_cnt_reg + CNT_W'(1);
        end
        else if (!fifo_wen && out_go)
        begin
            fifo_cnt_next = fifo_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (fifo_wen)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (out_go)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_wen)
        begin
            fifo_mem_reg[wr_ptr_reg] <= argb;
        end
    end

endmodule : caustic_alpha_texture_generator
`default_nettype wire

// ===== test/caustic_alpha_texture_generator_tb.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// caustic_alpha_texture_generator_tb
// Self-checking bench for the caustic alpha generator. It loads texels, sends
// pixel items under several frame counter settings and compares every ARGB
// item against a local fixed-point prediction kept in a small scoreboard.
// ---------------------------------------------------------------------------
module caustic_alpha_texture_generator_tb;
    import catg_pkg::*;

    // cycles with no item moving on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // idle wait once every result has come back
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_ITEMS    = 125;

    // -----------------------------------------------------------------------
    // Scoreboard: shadow texture, frame counter and the queue of ARGB words
    // still owed by the block.
    // -----------------------------------------------------------------------
    class caustic_scoreboard;
        logic [15:0] frame_count;
        texel_t      tex [TEX_DEPTH];
        bit          loaded [TEX_DEPTH];
        logic [31:0] argb_due [$];
        int          errors;
        int          loads_seen;
        int          pixels_checked;

        function new();
            frame_count    = '0;
            errors         = 0;
            loads_seen     = 0;
            pixels_checked = 0;
        endfunction

        // signed 32-bit division, truncating toward zero
        function logic [31:0] quot(logic [31:0] a, int d);
            return 32'($signed(a) / d);
        endfunction

        // the two 16.16 coordinate pairs of a pixel at the current frame
        function void coords(logic [6:0] x, logic [5:0] y,
                             output logic [31:0] u1, output logic [31:0] v1,
                             output logic [31:0] u2, output logic [31:0] v2);
            logic [31:0] c0, c1, tu;
            c0 = {frame_count, 16'h0000};
            c1 = ({16'h0000, frame_count} + 32'd1) << 16;   // wraps at 65535
            tu = 32'(x) << 17;
            u1 = tu - quot(c1, 6);
            v1 = ((32'd256 - 32'(y)) << 17) + quot(c0, 8);
            u2 = tu + quot(c0, 10);
            v2 = 32'(y) << 17;
        endfunction

        // texel index of one bilinear corner: 0 = top left, 1 = top right,
        // 2 = bottom left, 3 = bottom right; neighbours wrap at 256
        function logic [15:0] corner(logic [31:0] u, logic [31:0] v, int k);
            logic [7:0] cx, cy;
            cx = u[23:16] + 8'(k % 2);
            cy = v[23:16] + 8'(k / 2);
            return {cy, cx};
        endfunction

        function texel_t sample(logic [31:0] u, logic [31:0] v);
            logic [63:0] fx, fy, gx, gy, p00, p10, p01, p11, sum;
            fx  = 64'(u[15:0]);
            fy  = 64'(v[15:0]);
            gx  = 64'(FRAC_ONE) - fx;
            gy  = 64'(FRAC_ONE) - fy;
            p00 = 64'(tex[corner(u, v, 0)]);
            p10 = 64'(tex[corner(u, v, 1)]);
            p01 = 64'(tex[corner(u, v, 2)]);
            p11 = 64'(tex[corner(u, v, 3)]);
            sum = p00 * gx * gy + p10 * fx * gy + p01 * gx * fy + p11 * fx * fy;
            return sum[39:32];
        endfunction

        function void note_item(logic f, logic [15:0] addr, texel_t val,
                                logic [6:0] x, logic [5:0] y, logic [23:0] rgb);
            logic [31:0] u1, v1, u2, v2;
            logic [8:0]  avg;
            int          alpha;
            if (f == FUNC_LOAD)
            begin
                tex[addr]    = val;
                loaded[addr] = 1'b1;
                loads_seen++;
                return;
            end
            if (x >= IMAGE_WIDTH || y >= IMAGE_HEIGHT)
                return;
            coords(x, y, u1, v1, u2, v2);
            avg = (9'(sample(u1, v1)) + 9'(sample(u2, v2))) >> 1;
            if (avg >= ALPHA_KNEE_HI)
                alpha = 255 - 2 * (int'(avg) - int'(ALPHA_KNEE_HI));
            else if (avg >= ALPHA_KNEE_LO)
                alpha = 5 * (int'(avg) - int'(ALPHA_KNEE_LO));
            else
                alpha = 0;
            argb_due.push_back({8'(alpha / 3), rgb});
        endfunction

        function void check_result(logic [31:0] argb);
            logic [31:0] want;
            if (argb_due.size() == 0)
            begin
                $display("%0t: pixel_argb with nothing due, expected none, actual %08h",
                         $time, argb);
                errors++;
                return;
            end
            want = argb_due.pop_front();
            pixels_checked++;
            if (argb !== want)
            begin
                $display("%0t: pixel_argb mismatch, expected %08h, actual %08h",
                         $time, want, argb);
                errors++;
            end
        endfunction

        function int pending();
            return argb_due.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // -----------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wen       = 1'b0;
    logic [15:0] cfg_wdata     = '0;
    logic        in_valid      = 1'b0;
    logic        func          = FUNC_LOAD;
    logic [15:0] texel_address = '0;
    logic [7:0]  texel_value   = '0;
    logic [6:0]  pixel_x       = '0;
    logic [5:0]  pixel_y       = '0;
    logic [23:0] old_rgb       = '0;
    logic        out_stall     = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [31:0] pixel_argb;

    caustic_scoreboard board = new();

    bit calm           = 1'b0;   // set for a stretch with no idling on either side
    int items_sent     = 0;
    int frame_settings = 0;
    int quiet_cycles   = 0;

    always #4 clk = ~clk;

    caustic_alpha_texture_generator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .texel_address (texel_address),
        .texel_value   (texel_value),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .old_rgb       (old_rgb),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_argb    (pixel_argb)
    );

    // -----------------------------------------------------------------------
    // Input side. Every task is entered and left just after a rising edge, so
    // in_valid gets at most one nonblocking update per time step. in_stall is
    // read before the edge's updates land, i.e. as it was at the edge.
    // -----------------------------------------------------------------------
    task automatic send_item(logic f, logic [15:0] addr, texel_t val,
                             logic [6:0] x, logic [5:0] y, logic [23:0] rgb);
        // random gaps, roughly one cycle in five outside calm stretches
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        texel_address <= addr;
        texel_value   <= val;
        pixel_x       <= x;
        pixel_y       <= y;
        old_rgb       <= rgb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge; the payload stays put until the next item
        board.note_item(f, addr, val, x, y, rgb);
        items_sent++;
    endtask

    // texel values leaning high, so that both knees of the alpha curve are hit
    function automatic texel_t rand_texel();
        case ($urandom_range(0, 3))
            0:       return texel_t'($urandom_range(0, 255));
            1:       return texel_t'($urandom_range(128, 255));
            2:       return texel_t'($urandom_range(150, 200));
            default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    task automatic load_texel(logic [15:0] addr, texel_t val);
        send_item(FUNC_LOAD, addr, val, 7'($urandom), 6'($urandom), 24'($urandom));
    endtask

    // A pixel reads eight texels (two samples, four corners each). Texels
    // never loaded are loaded first; refill overwrites all eight with val.
    task automatic cover_texels(logic [6:0] x, logic [5:0] y, bit refill, texel_t val);
        logic [31:0] u1, v1, u2, v2;
        logic [15:0] addr;
        board.coords(x, y, u1, v1, u2, v2);
        for (int k = 0; k < 8; k++)
        begin
            addr = (k < 4) ? board.corner(u1, v1, k) : board.corner(u2, v2, k - 4);
            if (refill || !board.loaded[addr])
                load_texel(addr, refill ? val : rand_texel());
        end
    endtask

    task automatic send_pixel(logic [6:0] x, logic [5:0] y, logic [23:0] rgb,
                              bit refill, texel_t val);
        cover_texels(x, y, refill, val);
        send_item(FUNC_PIXEL, 16'($urandom), 8'($urandom), x, y, rgb);
    endtask

    // Frame counter writes happen only with the block idle: hold off the
    // sender until every pixel has come back, then let the pipeline settle.
    task automatic write_frame(logic [15:0] value);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        board.frame_count = value;
        frame_settings++;
    endtask

    // Roughly a third random loads anywhere in the texture, the rest pixels
    // with random position and colour (plus the loads they need first).
    task automatic run_phase(logic [15:0] value, bit no_idle);
        int stop_at;
        write_frame(value);
        calm    = no_idle;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 30)
                load_texel(16'($urandom_range(0, 65535)), rand_texel());
            else
                send_pixel(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                           24'($urandom), 1'b0, 8'd0);
        end
        calm = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Output side: random stall, check each accepted item
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(pixel_argb);
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, board.pending());
            $display("caustic_alpha_texture_generator_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_frame(16'd0);

        // directed: address and value extremes
        load_texel(16'h0000, 8'd255);
        load_texel(16'hFFFF, 8'd0);
        // flat texture under a pixel gives an exact average: right on the
        // upper knee (peak alpha), full white, and just below the knee
        send_pixel(7'd0,   6'd0,  24'h000000, 1'b1, 8'd160);
        send_pixel(7'd127, 6'd63, 24'hFFFFFF, 1'b1, 8'd255);
        send_pixel(7'd64,  6'd32, 24'h5A5A5A, 1'b1, 8'd159);

        // random phases; the calm one has no idling on either side, and
        // the counter's top value exercises the wrap of the next-frame term
        run_phase(16'd0,     1'b0);
        run_phase(16'hFFFF,  1'b1);
        run_phase(16'h8000,  1'b0);
        run_phase(16'h7FFF,  1'b0);
        run_phase(16'd1,     1'b0);
        run_phase(16'($urandom), 1'b0);
        run_phase(16'($urandom), 1'b0);

        // drain, then let the block settle to catch anything spurious
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d items: %0d texel loads and %0d pixels checked,",
                 items_sent, board.loads_seen, board.pixels_checked);
        $display("under %0d frame counter settings; %0d errors.",
                 frame_settings, board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("caustic_alpha_texture_generator_tb passed");
        else
            $display("caustic_alpha_texture_generator_tb failed");
        $finish;
    end

endmodule : caustic_alpha_texture_generator_tb
`default_nettype wire
